// ===== rtl/core/pnrf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnrf_pkg
// Shared types and constants for the per-node replay filter.
// ----------------------------------------------------------------------------
package pnrf_pkg;

   localparam int SEQ_W = 32;
   localparam int KEY_W = 32;

   typedef logic [SEQ_W-1:0] seq_type;
   typedef logic [KEY_W-1:0] key_type;
   typedef logic [2:0]       status_type;
   typedef logic [0:0]       csr_index_type;
   typedef logic             opcode_type;

   // request opcodes
   localparam opcode_type OP_CHECK = 1'b0;
   localparam opcode_type OP_RESET = 1'b1;

   // response status codes
   localparam status_type ST_OK     = 3'd0;
   localparam status_type ST_REBOOT = 3'd1;
   localparam status_type ST_REPLAY = 3'd2;
   localparam status_type ST_FULL   = 3'd3;
   localparam status_type ST_RESET  = 3'd4;

   // CSR indexes and reset values
   localparam csr_index_type CSR_HIGH_MARK = 1'b0;
   localparam csr_index_type CSR_LOW_MARK  = 1'b1;
   localparam seq_type HIGH_MARK_RST = 32'd500;
   localparam seq_type LOW_MARK_RST  = 32'd100;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP,
      S_DECIDE,
      S_SCAN,
      S_UPDATE,
      S_FINISH
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/core/pnrf_ring_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnrf_ring_mem
// Simple dual-port RAM holding every node's sequence ring, registered read.
// ----------------------------------------------------------------------------
module pnrf_ring_mem #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  wire                   clock,
   input  wire                   wr_en,
   input  wire  [ADDR_W-1:0]     wr_addr,
   input  pnrf_pkg::seq_type     wr_data,
   input  wire                   rd_en,
   input  wire  [ADDR_W-1:0]     rd_addr,
   output pnrf_pkg::seq_type     rd_data
);
   import pnrf_pkg::*;

   seq_type mem [DEPTH];
   seq_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/core/per_node_replay_filter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_node_replay_filter_core
// Per-sender replay filter over a window of recently accepted sequences.
// ----------------------------------------------------------------------------
// Usage:
//  - req_*: one request per node packet. opcode check tests req_seq for node
//    req_node_key; opcode reset clears that node's window (slot stays held).
//  - rsp_*: exactly one response per request, rsp_accepted plus rsp_status
//    (ok, ok after reboot clear, replay, table full, reset done).
//  - csr_*: write-only marks for reboot detection, always ready. Write only
//    while no request is in flight.
// Steps: accept, key lookup, slot decision, ring scan, update, finish.
//  A check scans the node's valid ring entries, its fill (at most RING_DEPTH);
//  a replay ends the scan early. The scan reads one ring entry per cycle
//  (one read port); table full and reset skip the scan and update.
// One request at a time: req_ready is high only while idle. The finished
//  response sits in an output register, so a new request is taken while it
//  waits; a stalled receiver holds the next request in the finish state.
// Reset: synchronous, clears all slots and window metadata.
//  Ring RAM contents need no clearing; the per-slot fill count marks which
//  entries are valid.
// ----------------------------------------------------------------------------
module per_node_replay_filter_core #(
   parameter int NODE_SLOTS = 8,
   parameter int RING_DEPTH = 32
) (
   input  wire                       clock,
   input  wire                       reset,
   // request channel
   input  wire                       req_valid,
   output logic                      req_ready,
   input  pnrf_pkg::opcode_type      req_opcode,
   input  pnrf_pkg::key_type         req_node_key,
   input  pnrf_pkg::seq_type         req_seq,
   // response channel
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output logic                      rsp_accepted,
   output pnrf_pkg::status_type      rsp_status,
   // csr write channel
   input  wire                       csr_valid,
   output logic                      csr_ready,
   input  pnrf_pkg::csr_index_type   csr_index,
   input  pnrf_pkg::seq_type         csr_wdata
);
   import pnrf_pkg::*;

   localparam int SLOT_W       = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
   localparam int POS_W        = $clog2(RING_DEPTH);
   localparam int FILL_W       = $clog2(RING_DEPTH + 1);
   localparam int RING_ENTRIES = NODE_SLOTS * RING_DEPTH;
   localparam int ADDR_W       = $clog2(RING_ENTRIES);

   // control
   state_type state_ff, state_in;

   // request capture
   opcode_type op_ff;
   key_type    key_ff;
   seq_type    seq_ff;

   // slot table
   logic [NODE_SLOTS-1:0] slot_active_ff;
   key_type               slot_key_ff [NODE_SLOTS];
   logic [NODE_SLOTS-1:0] match_ff;
   logic [NODE_SLOTS-1:0] free_ff;
   logic [SLOT_W-1:0]     slot_ff;

   // per-slot window metadata
   logic [POS_W-1:0]  ring_pos_ff  [NODE_SLOTS];
   logic [FILL_W-1:0] ring_fill_ff [NODE_SLOTS];
   seq_type           high_seq_ff  [NODE_SLOTS];

   // scan
   logic [FILL_W-1:0] rd_idx_ff;
   logic              rd_vld_ff;

   // result
   status_type status_ff;
   logic       acc_ff;
   logic       rsp_valid_ff;
   logic       rsp_accepted_ff;
   status_type rsp_status_ff;

   // csr
   seq_type high_mark_ff;
   seq_type low_mark_ff;

   // combinational helpers
   logic              hit_any, free_any;
   logic [SLOT_W-1:0] hit_idx, free_idx;
   logic              scan_issue, scan_hit, scan_done;
   logic              rsp_free;
   logic              reboot;
   logic [POS_W-1:0]  base_pos, pos_next;
   logic [FILL_W-1:0] base_fill, fill_next;
   seq_type           base_high;

   // ring RAM ports
   logic              ring_we, ring_re;
   logic [ADDR_W-1:0] ring_waddr, ring_raddr;
   seq_type           ring_rdata;

   pnrf_ring_mem #(
      .DEPTH  (RING_ENTRIES),
      .ADDR_W (ADDR_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_waddr),
      .wr_data (seq_ff),
      .rd_en   (ring_re),
      .rd_addr (ring_raddr),
      .rd_data (ring_rdata)
   );

   // lowest matching slot and lowest free slot from the registered vectors
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int i = NODE_SLOTS - 1; i >= 0; i--) begin
         if (match_ff[i]) hit_idx = SLOT_W'(i);
         if (free_ff[i])  free_idx = SLOT_W'(i);
      end
      hit_any  = |match_ff;
      free_any = |free_ff;
   end

   // scan bookkeeping: issue one read per cycle, compare the one returned
   assign scan_issue = (rd_idx_ff < ring_fill_ff[slot_ff]);
   assign scan_hit   = rd_vld_ff && (ring_rdata == seq_ff);
   assign scan_done  = !scan_issue && !rd_vld_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   // reboot rule and window update for the selected slot
   always_comb begin
      reboot    = (high_seq_ff[slot_ff] > high_mark_ff) && (seq_ff < low_mark_ff);
      base_pos  = reboot ? '0 : ring_pos_ff[slot_ff];
      base_fill = reboot ? '0 : ring_fill_ff[slot_ff];
      base_high = reboot ? '0 : high_seq_ff[slot_ff];
      pos_next  = (base_pos == POS_W'(RING_DEPTH - 1)) ? '0 : base_pos + 1'b1;
      fill_next = (base_fill == FILL_W'(RING_DEPTH)) ? base_fill : base_fill + 1'b1;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_LOOKUP;
         end
         S_LOOKUP: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (op_ff == OP_RESET)        state_in = S_FINISH;
            else if (hit_any || free_any) state_in = S_SCAN;
            else                          state_in = S_FINISH;
         end
         S_SCAN: begin
            if (scan_hit)       state_in = S_FINISH;
            else if (scan_done) state_in = S_UPDATE;
         end
         S_UPDATE: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs and RAM controls
   always_comb begin
      req_ready  = 1'b0;
      ring_re    = 1'b0;
      ring_we    = 1'b0;
      ring_raddr = ADDR_W'(slot_ff) * ADDR_W'(RING_DEPTH)
                 + ADDR_W'(rd_idx_ff[POS_W-1:0]);
      ring_waddr = ADDR_W'(slot_ff) * ADDR_W'(RING_DEPTH) + ADDR_W'(base_pos);
      case (state_ff)
         S_IDLE:   req_ready = 1'b1;
         S_SCAN:   ring_re   = scan_issue;
         S_UPDATE: ring_we   = 1'b1;
         default:  ;
      endcase
   end

   // control and metadata registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         slot_active_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         rd_vld_ff      <= 1'b0;
         high_mark_ff   <= HIGH_MARK_RST;
         low_mark_ff    <= LOW_MARK_RST;
         for (int i = 0; i < NODE_SLOTS; i++) begin
            ring_pos_ff[i]  <= '0;
            ring_fill_ff[i] <= '0;
            high_seq_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;

         if (csr_valid) begin
            if (csr_index == CSR_HIGH_MARK) high_mark_ff <= csr_wdata;
            if (csr_index == CSR_LOW_MARK)  low_mark_ff  <= csr_wdata;
         end

         case (state_ff)
            S_DECIDE: begin
               rd_vld_ff <= 1'b0;
               if (op_ff == OP_RESET) begin
                  if (hit_any) begin
                     ring_pos_ff[hit_idx]  <= '0;
                     ring_fill_ff[hit_idx] <= '0;
                     high_seq_ff[hit_idx]  <= '0;
                  end
               end else if (!hit_any && free_any) begin
                  // claim a fresh slot with an empty window
                  slot_active_ff[free_idx] <= 1'b1;
                  ring_pos_ff[free_idx]    <= '0;
                  ring_fill_ff[free_idx]   <= '0;
                  high_seq_ff[free_idx]    <= '0;
               end
            end
            S_SCAN: begin
               rd_vld_ff <= scan_issue;
            end
            S_UPDATE: begin
               ring_pos_ff[slot_ff]  <= pos_next;
               ring_fill_ff[slot_ff] <= fill_next;
               high_seq_ff[slot_ff]  <= (seq_ff > base_high) ? seq_ff : base_high;
            end
            default: ;
         endcase

         if (state_ff == S_FINISH && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_ff  <= req_opcode;
               key_ff <= req_node_key;
               seq_ff <= req_seq;
            end
         end
         S_LOOKUP: begin
            for (int i = 0; i < NODE_SLOTS; i++) begin
               match_ff[i] <= slot_active_ff[i] && (slot_key_ff[i] == key_ff);
               free_ff[i]  <= !slot_active_ff[i];
            end
         end
         S_DECIDE: begin
            rd_idx_ff <= '0;
            slot_ff   <= hit_any ? hit_idx : free_idx;
            acc_ff    <= 1'b0;
            if (op_ff == OP_RESET)           status_ff <= ST_RESET;
            else if (!hit_any && !free_any) status_ff <= ST_FULL;
            if (op_ff == OP_CHECK && !hit_any && free_any) begin
               slot_key_ff[free_idx] <= key_ff;
            end
         end
         S_SCAN: begin
            if (scan_issue) rd_idx_ff <= rd_idx_ff + 1'b1;
            if (scan_hit)   status_ff <= ST_REPLAY;
         end
         S_UPDATE: begin
            acc_ff    <= 1'b1;
            status_ff <= reboot ? ST_REBOOT : ST_OK;
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_accepted_ff <= acc_ff;
               rsp_status_ff   <= status_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_accepted_ff;
   assign rsp_status   = rsp_status_ff;
   assign csr_ready    = 1'b1;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   // an accepted packet always carries an ok or reboot status
   a_acc_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> (rsp_status == ST_OK || rsp_status == ST_REBOOT))
      else $error("accepted response with non-accept status");

   // the ring is only written for a slot that is held
   a_update_active: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_UPDATE |-> slot_active_ff[slot_ff])
      else $error("ring update for an inactive slot");

   // the scan never runs past the slot's fill count
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> rd_idx_ff <= ring_fill_ff[slot_ff])
      else $error("ring scan index beyond fill");

   // one request at a time: no new request right after one is taken
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

endmodule
`default_nettype wire
